/* hdl/rdx_pkg.sv */
// shared constants for the report deframer with xor check
`default_nettype none

package rdx_pkg;

    // default report size in bytes
    localparam int REPORT_BYTES_DEF = 32;

    // header and check bytes around the payload
    localparam int HEAD_AND_CHECK = 4;

    // status, flag values of the report header
    localparam logic [7:0] ST_LAST = 8'h02;
    localparam logic [7:0] ST_MORE = 8'h82;
    localparam logic [7:0] ST_FLAG = 8'h55;

    // reset value of the capacity register
    localparam logic [15:0] MAX_MSG_RESET = 16'd32;

    // result kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_ACCEPT  = 2'd1;
    localparam logic [1:0] KIND_REJECT  = 2'd2;

    // error codes
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_STATUS   = 3'd1;
    localparam logic [2:0] ERR_FLAG     = 3'd2;
    localparam logic [2:0] ERR_LENGTH   = 3'd3;
    localparam logic [2:0] ERR_CHECK    = 3'd4;
    localparam logic [2:0] ERR_OVERFLOW = 3'd5;

endpackage

`default_nettype wire

/* hdl/rdx_if.sv */
// stream interfaces for report bytes in and results out
`default_nettype none

interface rdx_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       report_start;

    modport source (output valid, output in_byte, output report_start, input ready);
    modport sink   (input valid, input in_byte, input report_start, output ready);
endinterface

interface rdx_res_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_data;
    logic [1:0]  kind;
    logic [2:0]  error_code;
    logic        message_done;
    logic [15:0] message_length;

    modport source (output valid, output out_data, output kind, output error_code,
                    output message_done, output message_length, input ready);
    modport sink   (input valid, input out_data, input kind, input error_code,
                    input message_done, input message_length, output ready);
endinterface

`default_nettype wire

/* hdl/report_deframer_xor_check_core.sv */
// report deframer: header checks, payload pass-through, xor check and message total
//
// usage
//   bytes_ch carries one report byte per transfer, report_start marks byte 0 of a
//   report. results_ch carries at most one result per input transfer: a payload
//   byte, a report accepted (with the message total on the last report) or a
//   report rejected with an error code.
//   the apb port holds one register, max_message_bytes at address 0, the receive
//   capacity; write it only while the block is idle.
// timing
//   one input transfer per cycle unless stalled (see below). each result is loaded
//   into the output register by its input transfer; the state update and the result
//   decision are done in the same cycle as the transfer, from the state registers.
// reset
//   rst_n clears the parser to wait for a report start, clears the message and
//   sets the capacity to 32.
// stall
//   a held result in the output register blocks new input only while results_ch
//   is not ready; bytes_ch.ready = output register empty or being taken.
`default_nettype none

module report_deframer_xor_check_core #(
    parameter int REPORT_BYTES = rdx_pkg::REPORT_BYTES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    rdx_byte_if.sink         bytes_ch,
    rdx_res_if.source        results_ch,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    // largest payload length and the width that holds it
    localparam int MAX_LEN = REPORT_BYTES - rdx_pkg::HEAD_AND_CHECK;
    localparam int LEN_W   = $clog2(MAX_LEN + 1);

    // parser phases
    localparam logic [2:0] PH_WAIT    = 3'd0;
    localparam logic [2:0] PH_FLAG    = 3'd1;
    localparam logic [2:0] PH_LENGTH  = 3'd2;
    localparam logic [2:0] PH_PAYLOAD = 3'd3;
    localparam logic [2:0] PH_CHECK   = 3'd4;
    localparam logic [2:0] PH_PAD     = 3'd5;

    // configuration
    logic [15:0] max_msg_reg;
    logic        cfg_write;

    // parser state
    logic [2:0]       phase_reg, phase_next;
    logic [LEN_W-1:0] rep_len_reg, rep_len_next;
    logic [LEN_W-1:0] seen_reg, seen_next;
    logic [LEN_W:0]   seen_inc;
    logic [7:0]       xor_reg, xor_next;
    logic             more_reg, more_next;
    logic [15:0]      total_reg, total_next;

    // result register
    logic        res_valid_reg, res_valid_next;
    logic        res_fire;
    logic [7:0]  res_data_reg, res_data_next;
    logic [1:0]  res_kind_reg, res_kind_next;
    logic [2:0]  res_err_reg, res_err_next;
    logic        res_done_reg, res_done_next;
    logic [15:0] res_len_reg, res_len_next;

    logic       in_xfer;
    logic [7:0] b;

    // apb: the register sits in the lower word, higher word reads zero
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && !paddr[2];
    assign prdata    = paddr[2] ? 32'd0 : {16'd0, max_msg_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_msg_reg <= rdx_pkg::MAX_MSG_RESET;
        end
        else if (cfg_write)
        begin
            max_msg_reg <= pwdata[15:0];
        end
    end

    // a new byte is taken when the result register is empty or being emptied
    assign bytes_ch.ready = !res_valid_reg || results_ch.ready;
    assign in_xfer        = bytes_ch.valid && bytes_ch.ready;
    assign b              = bytes_ch.in_byte;
    assign seen_inc       = {1'b0, seen_reg} + {{LEN_W{1'b0}}, 1'b1};

    always_comb
    begin
        phase_next    = phase_reg;
        rep_len_next  = rep_len_reg;
        seen_next     = seen_reg;
        xor_next      = xor_reg;
        more_next     = more_reg;
        total_next    = total_reg;
        res_fire      = 1'b0;
        res_data_next = 8'd0;
        res_kind_next = rdx_pkg::KIND_REJECT;
        res_err_next  = rdx_pkg::ERR_NONE;
        res_done_next = 1'b0;
        res_len_next  = 16'd0;

        if (in_xfer)
        begin
            if (bytes_ch.report_start)
            begin
                // a start inside an unfinished report drops the message silently
                if (phase_reg != PH_WAIT && phase_reg != PH_PAD)
                begin
                    total_next   = 16'd0;
                    more_next    = 1'b0;
                    seen_next    = '0;
                    rep_len_next = '0;
                    xor_next     = 8'd0;
                end
                if (b == rdx_pkg::ST_LAST || b == rdx_pkg::ST_MORE)
                begin
                    more_next  = (b == rdx_pkg::ST_MORE);
                    phase_next = PH_FLAG;
                end
                else
                begin
                    res_fire     = 1'b1;
                    res_err_next = rdx_pkg::ERR_STATUS;
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_FLAG:
                    begin
                        if (b != rdx_pkg::ST_FLAG)
                        begin
                            res_fire     = 1'b1;
                            res_err_next = rdx_pkg::ERR_FLAG;
                        end
                        else
                        begin
                            phase_next = PH_LENGTH;
                        end
                    end
                    PH_LENGTH:
                    begin
                        if (b > 8'(MAX_LEN))
                        begin
                            res_fire     = 1'b1;
                            res_err_next = rdx_pkg::ERR_LENGTH;
                        end
                        else
                        begin
                            rep_len_next = b[LEN_W-1:0];
                            seen_next    = '0;
                            xor_next     = b;
                            phase_next   = (b == 8'd0) ? PH_CHECK : PH_PAYLOAD;
                        end
                    end
                    PH_PAYLOAD:
                    begin
                        if (total_reg >= max_msg_reg)
                        begin
                            res_fire     = 1'b1;
                            res_err_next = rdx_pkg::ERR_OVERFLOW;
                        end
                        else
                        begin
                            total_next    = total_reg + 16'd1;
                            xor_next      = xor_reg ^ b;
                            seen_next     = seen_inc[LEN_W-1:0];
                            if (seen_inc >= {1'b0, rep_len_reg})
                            begin
                                phase_next = PH_CHECK;
                            end
                            res_fire      = 1'b1;
                            res_kind_next = rdx_pkg::KIND_PAYLOAD;
                            res_data_next = b;
                        end
                    end
                    PH_CHECK:
                    begin
                        if (b != xor_reg)
                        begin
                            res_fire     = 1'b1;
                            res_err_next = rdx_pkg::ERR_CHECK;
                        end
                        else
                        begin
                            phase_next    = PH_PAD;
                            res_fire      = 1'b1;
                            res_kind_next = rdx_pkg::KIND_ACCEPT;
                            seen_next     = '0;
                            rep_len_next  = '0;
                            xor_next      = 8'd0;
                            if (!more_reg)
                            begin
                                // last report: hand out the total, start a new message
                                res_done_next = 1'b1;
                                res_len_next  = total_reg;
                                total_next    = 16'd0;
                                more_next     = 1'b0;
                            end
                        end
                    end
                    default:
                    begin
                        // waiting or padding: byte ignored
                    end
                endcase
            end

            // any rejection clears the message and waits for a start
            if (res_fire && res_kind_next == rdx_pkg::KIND_REJECT)
            begin
                phase_next   = PH_WAIT;
                total_next   = 16'd0;
                more_next    = 1'b0;
                seen_next    = '0;
                rep_len_next = '0;
                xor_next     = 8'd0;
            end
        end
    end

    always_comb
    begin
        if (res_fire)
        begin
            res_valid_next = 1'b1;
        end
        else if (results_ch.ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_WAIT;
            rep_len_reg   <= '0;
            seen_reg      <= '0;
            xor_reg       <= 8'd0;
            more_reg      <= 1'b0;
            total_reg     <= 16'd0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            rep_len_reg   <= rep_len_next;
            seen_reg      <= seen_next;
            xor_reg       <= xor_next;
            more_reg      <= more_next;
            total_reg     <= total_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // result payload, loaded with each new result
    always_ff @(posedge clk)
    begin
        if (res_fire)
        begin
            res_data_reg <= res_data_next;
            res_kind_reg <= res_kind_next;
            res_err_reg  <= res_err_next;
            res_done_reg <= res_done_next;
            res_len_reg  <= res_len_next;
        end
    end

    assign results_ch.valid          = res_valid_reg;
    assign results_ch.out_data       = res_data_reg;
    assign results_ch.kind           = res_kind_reg;
    assign results_ch.error_code     = res_err_reg;
    assign results_ch.message_done   = res_done_reg;
    assign results_ch.message_length = res_len_reg;

endmodule

`default_nettype wire

/* bench/tb_report_deframer_xor_check_core.sv */
// self-checking deframer bench: directed and random report streams against a byte-level predictor
`default_nettype none

module tb_report_deframer_xor_check_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CLK_HALF     = 4;
    localparam int          RPT          = rdx_pkg::REPORT_BYTES_DEF;
    localparam int          MAX_PAYLOAD  = RPT - rdx_pkg::HEAD_AND_CHECK;
    localparam int          ITEM_GOAL    = 650;
    localparam int          N_SETTINGS   = 6;
    localparam int          DRAIN_CYCLES = 4;
    localparam int          LONG_HOLD    = 300;
    localparam int          STALL_LIMIT  = 2000;
    localparam int          MAX_GAP      = 6;
    localparam logic [2:0]  ADDR_MAX_MSG = 3'd0;

    // parser position inside a report, as the predictor tracks it
    typedef enum logic [2:0] {
        S_HUNT, S_FLAG, S_LEN, S_PAY, S_CHK, S_PAD
    } parse_state_t;

    typedef struct packed {
        logic [7:0] value;
        logic       first;
    } report_byte_t;

    typedef struct packed {
        logic [7:0]  data;
        logic [1:0]  kind;
        logic [2:0]  code;
        logic        done;
        logic [15:0] total;
    } deframe_result_t;

    logic        clk   = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    wire  [31:0] prdata;
    wire         pready;

    rdx_byte_if bytes_if ();
    rdx_res_if  results_if ();

    report_deframer_xor_check_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .bytes_ch   (bytes_if),
        .results_ch (results_if),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // bytes still to be offered, and results still owed by the block
    report_byte_t    pending_bytes [$];
    deframe_result_t expected_results [$];

    // predictor copy of the block state and its capacity register
    parse_state_t pr_state;
    logic [4:0]   pr_len;
    logic [4:0]   pr_count;
    logic [7:0]   pr_sum;
    logic         pr_chain;
    logic [15:0]  pr_total;
    logic [15:0]  pr_cap;

    // run bookkeeping
    int           errors        = 0;
    int           items_sent    = 0;
    int           byte_xfers    = 0;
    int           results_seen  = 0;
    int           quiet_cycles  = 0;
    int           n_kind [4]    = '{0, 0, 0, 0};
    int           n_done        = 0;
    bit           no_idle       = 1'b0;
    int           long_hold_req = 0;
    int           long_hold_ack = 0;
    int           send_gap      = 0;
    int           hold_cnt      = 0;
    report_byte_t next_byte;
    deframe_result_t got;
    deframe_result_t want;
    deframe_result_t predicted;
    logic [15:0]  cap_plan [N_SETTINGS];

    always
    begin
        #(CLK_HALF) clk = 1'b1;
        #(CLK_HALF) clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // forget the message gathered so far
    function automatic void drop_message();
        pr_total = '0;
        pr_chain = 1'b0;
        pr_count = '0;
        pr_len   = '0;
        pr_sum   = '0;
    endfunction

    function automatic bit reject_report(input logic [2:0] code, output deframe_result_t r);
        drop_message();
        pr_state = S_HUNT;
        r        = '0;
        r.kind   = rdx_pkg::KIND_REJECT;
        r.code   = code;
        return 1'b1;
    endfunction

    // one byte through the deframer; returns 1 when a result is due
    function automatic bit deframe_byte(input logic [7:0] b, input logic first,
                                        output deframe_result_t r);
        r = '0;
        if (first)
        begin
            // a start in the middle of a report throws away the whole message
            if (pr_state != S_HUNT && pr_state != S_PAD)
                drop_message();
            if (b == rdx_pkg::ST_LAST || b == rdx_pkg::ST_MORE)
            begin
                pr_chain = (b == rdx_pkg::ST_MORE);
                pr_state = S_FLAG;
                return 1'b0;
            end
            return reject_report(rdx_pkg::ERR_STATUS, r);
        end
        case (pr_state)
            S_FLAG:
            begin
                if (b != rdx_pkg::ST_FLAG)
                    return reject_report(rdx_pkg::ERR_FLAG, r);
                pr_state = S_LEN;
                return 1'b0;
            end
            S_LEN:
            begin
                if (b > MAX_PAYLOAD)
                    return reject_report(rdx_pkg::ERR_LENGTH, r);
                pr_len   = b[4:0];
                pr_count = '0;
                pr_sum   = b;
                // an empty report goes straight to its check byte
                pr_state = (b == 8'd0) ? S_CHK : S_PAY;
                return 1'b0;
            end
            S_PAY:
            begin
                // capacity is tested before the byte is counted
                if (pr_total >= pr_cap)
                    return reject_report(rdx_pkg::ERR_OVERFLOW, r);
                pr_total = pr_total + 16'd1;
                pr_sum   = pr_sum ^ b;
                pr_count = pr_count + 5'd1;
                if (pr_count >= pr_len)
                    pr_state = S_CHK;
                r.data = b;
                r.kind = rdx_pkg::KIND_PAYLOAD;
                return 1'b1;
            end
            S_CHK:
            begin
                if (b != pr_sum)
                    return reject_report(rdx_pkg::ERR_CHECK, r);
                pr_state = S_PAD;
                r.kind   = rdx_pkg::KIND_ACCEPT;
                if (pr_chain)
                begin
                    pr_count = '0;
                    pr_len   = '0;
                    pr_sum   = '0;
                end
                else
                begin
                    // last report closes the message and reports its size
                    r.done  = 1'b1;
                    r.total = pr_total;
                    drop_message();
                end
                return 1'b1;
            end
            default:
                return 1'b0;    // waiting for a start, or inside padding
        endcase
    endfunction

    // ------------------------------------------------------------------
    // stimulus building
    // ------------------------------------------------------------------

    // lay out one report and queue its first `keep` bytes
    task automatic queue_report(input logic [7:0] status, input logic [7:0] flag,
                                input logic [7:0] len_b, input bit bad_check,
                                input int keep);
        logic [7:0] frame [RPT];
        logic [7:0] sum;
        int         n_pay;
        n_pay    = (len_b <= MAX_PAYLOAD) ? int'(len_b) : MAX_PAYLOAD;
        frame[0] = status;
        frame[1] = flag;
        frame[2] = len_b;
        sum      = len_b;
        for (int i = 0; i < n_pay; i++)
        begin
            frame[3 + i] = 8'($urandom);
            sum          = sum ^ frame[3 + i];
        end
        frame[3 + n_pay] = bad_check ? (sum ^ 8'($urandom_range(1, 255))) : sum;
        // padding carries junk, the block must not look at it
        for (int i = 4 + n_pay; i < RPT; i++)
            frame[i] = 8'($urandom);
        for (int i = 0; i < keep && i < RPT; i++)
            pending_bytes.push_back('{value: frame[i], first: (i == 0)});
        items_sent += (keep < RPT) ? keep : RPT;
    endtask

    // one message of 1..4 reports, mostly well formed, with faults mixed in
    task automatic queue_message();
        int         n_rep;
        int         pick;
        int         keep;
        logic [7:0] status;
        logic [7:0] flag;
        logic [7:0] len_b;
        bit         bad_check;
        n_rep = $urandom_range(1, 4);
        for (int r = 0; r < n_rep; r++)
        begin
            status    = (r == n_rep - 1) ? rdx_pkg::ST_LAST : rdx_pkg::ST_MORE;
            flag      = rdx_pkg::ST_FLAG;
            bad_check = 1'b0;
            keep      = RPT;
            pick      = $urandom_range(0, 9);
            if (pick == 0)
                len_b = 8'd0;
            else if (pick == 1)
                len_b = 8'(MAX_PAYLOAD);
            else
                len_b = 8'($urandom_range(1, MAX_PAYLOAD));
            case ($urandom_range(0, 19))
                0:
                begin
                    do
                        status = 8'($urandom);
                    while (status == rdx_pkg::ST_LAST || status == rdx_pkg::ST_MORE);
                end
                1:
                begin
                    do
                        flag = 8'($urandom);
                    while (flag == rdx_pkg::ST_FLAG);
                end
                2: len_b     = 8'($urandom_range(MAX_PAYLOAD + 1, 255));
                3: bad_check = 1'b1;
                4: keep      = $urandom_range(1, 3 + int'(len_b));  // cut short
                default: ;
            endcase
            queue_report(status, flag, len_b, bad_check, keep);
            // stray bytes between reports, now and then a stray start
            if ($urandom_range(0, 7) == 0)
            begin
                pick = $urandom_range(1, 3);
                for (int i = 0; i < pick; i++)
                begin
                    pending_bytes.push_back('{value: 8'($urandom),
                                              first: ($urandom_range(0, 5) == 0)});
                    items_sent++;
                end
            end
        end
    endtask

    // apb write of the capacity register, setup then access
    task automatic write_capacity(input logic [15:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ADDR_MAX_MSG;
        pwdata  <= {16'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        pr_cap  = value;
        @(negedge clk);
    endtask

    // everything offered, every result back, then a drain for header bytes
    task automatic wait_drained();
        while (pending_bytes.size() != 0 || bytes_if.valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // byte driver: one drawn gap per byte, holds the byte until its transfer
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_if.valid        <= 1'b0;
            bytes_if.in_byte      <= '0;
            bytes_if.report_start <= 1'b0;
            send_gap = 0;
        end
        else if (!bytes_if.valid || bytes_if.ready)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                bytes_if.valid <= 1'b0;
            end
            else if (pending_bytes.size() != 0)
            begin
                next_byte = pending_bytes.pop_front();
                bytes_if.valid        <= 1'b1;
                bytes_if.in_byte      <= next_byte.value;
                bytes_if.report_start <= next_byte.first;
                send_gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            end
            else
            begin
                bytes_if.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // result receiver: a drawn stall after each transfer, plus one long hold
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            results_if.ready <= 1'b0;
            hold_cnt = 0;
        end
        else
        begin
            if (long_hold_req != long_hold_ack)
            begin
                // long back-pressure so the output register fills and input stalls
                long_hold_ack = long_hold_req;
                hold_cnt      = LONG_HOLD;
            end
            else if (results_if.valid && results_if.ready)
                hold_cnt = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            else if (hold_cnt > 0)
                hold_cnt--;
            results_if.ready <= (hold_cnt == 0);
        end
    end

    // ------------------------------------------------------------------
    // monitor: predict on each byte transfer, check each result transfer
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (bytes_if.valid && bytes_if.ready)
            begin
                byte_xfers++;
                if (deframe_byte(bytes_if.in_byte, bytes_if.report_start, predicted))
                    expected_results.push_back(predicted);
            end
            if (results_if.valid && results_if.ready)
            begin
                results_seen++;
                got = '{results_if.out_data, results_if.kind, results_if.error_code,
                        results_if.message_done, results_if.message_length};
                if (expected_results.size() == 0)
                begin
                    errors++;
                    $display({"%0t ns: result with nothing expected, ",
                              "actual data %h kind %0d code %0d done %0b total %0d"},
                             $time, got.data, got.kind, got.code, got.done, got.total);
                end
                else
                begin
                    want = expected_results.pop_front();
                    n_kind[want.kind]++;
                    if (want.done)
                        n_done++;
                    if (got.data !== want.data || got.kind !== want.kind ||
                        got.code !== want.code || got.done !== want.done ||
                        got.total !== want.total)
                    begin
                        errors++;
                        $display({"%0t ns: result mismatch, ",
                                  "expected data %h kind %0d code %0d done %0b total %0d"},
                                 $time, want.data, want.kind, want.code, want.done,
                                 want.total);
                        $display({"%0t ns:                   ",
                                  "actual data %h kind %0d code %0d done %0b total %0d"},
                                 $time, got.data, got.kind, got.code, got.done, got.total);
                    end
                end
            end
            // watchdog on cycles without any transfer
            if ((bytes_if.valid && bytes_if.ready) || (results_if.valid && results_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t ns: no transfer for %0d cycles, %0d results outstanding",
                         $time, quiet_cycles, expected_results.size());
                $display("report_deframer_xor_check_core regression: fail");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // sequence: reset, directed reports, then random messages per capacity
    // ------------------------------------------------------------------
    initial
    begin
        int goal;
        int mark;

        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;

        pr_state = S_HUNT;
        drop_message();
        pr_cap   = rdx_pkg::MAX_MSG_RESET;

        // capacity settings: reset value, both extremes, one byte, mid, random
        cap_plan = '{rdx_pkg::MAX_MSG_RESET, 16'h0000, 16'hFFFF, 16'd1, 16'd60,
                     16'($urandom_range(2, 200))};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int s = 0; s < N_SETTINGS; s++)
        begin
            if (s > 0)
                write_capacity(cap_plan[s]);
            if (s == 0)
            begin
                // stray byte with no start while waiting
                pending_bytes.push_back('{value: 8'hA5, first: 1'b0});
                items_sent++;
                // header faults: status, start flag, oversized length
                queue_report(8'h00, rdx_pkg::ST_FLAG, 8'd0, 1'b0, 1);
                queue_report(rdx_pkg::ST_LAST, 8'hAA, 8'd0, 1'b0, 2);
                queue_report(rdx_pkg::ST_LAST, rdx_pkg::ST_FLAG, 8'hFF, 1'b0, 3);
                // empty last report, one pad byte
                queue_report(rdx_pkg::ST_LAST, rdx_pkg::ST_FLAG, 8'd0, 1'b0, 5);
                // report with a wrong check byte, cut off before that byte
                queue_report(rdx_pkg::ST_MORE, rdx_pkg::ST_FLAG, 8'd1, 1'b1, 4);
                // report cut off by a new start, then a two-report message
                queue_report(rdx_pkg::ST_MORE, rdx_pkg::ST_FLAG, 8'd2, 1'b0, 4);
                queue_report(rdx_pkg::ST_MORE, rdx_pkg::ST_FLAG, 8'd1, 1'b0, 6);
                queue_report(rdx_pkg::ST_LAST, rdx_pkg::ST_FLAG, 8'd1, 1'b0, 5);
            end
            else if (s == 1)
            begin
                // zero capacity: first payload byte overflows
                queue_report(rdx_pkg::ST_LAST, rdx_pkg::ST_FLAG, 8'd1, 1'b0, 5);
            end

            // one setting runs back to back on both sides
            no_idle = (s == 2);
            goal    = (s + 1) * ITEM_GOAL / N_SETTINGS;
            while (items_sent < goal)
                queue_message();

            if (s == 4)
            begin
                // let some traffic flow, then hold the receiver off
                mark = results_seen + 8;
                while (results_seen < mark)
                    @(negedge clk);
                long_hold_req++;
            end
            wait_drained();
        end
        no_idle = 1'b0;

        $display("covered %0d byte transfers over %0d capacity settings (0 and 65535 included)",
                 byte_xfers, N_SETTINGS);
        $display("results: %0d payload, %0d accepted (%0d message ends), %0d rejected",
                 n_kind[rdx_pkg::KIND_PAYLOAD], n_kind[rdx_pkg::KIND_ACCEPT], n_done,
                 n_kind[rdx_pkg::KIND_REJECT]);
        if (errors == 0)
            $display("report_deframer_xor_check_core regression: pass");
        else
            $display("report_deframer_xor_check_core regression: fail");
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
hdl/rdx_pkg.sv
hdl/rdx_if.sv
hdl/report_deframer_xor_check_core.sv
bench/tb_report_deframer_xor_check_core.sv
